// ===== sv/utar_pkg.sv =====
// Package for the unsigned-to-ASCII radix converter.
// Holds the word types, the conversion constants and the digit-to-character function.
// No dependencies.
`default_nettype none

package utar_pkg;

   // Value width and the fixed field widths
   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 8;
   localparam int DIGIT_W     = RADIX_W;

   // Base limits and character offsets
   localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
   localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'd48;
   localparam logic [CHAR_W-1:0]  LOWER_OFFSET = 8'd87;
   localparam logic [CHAR_W-1:0]  UPPER_OFFSET = 8'd55;
   localparam logic [DIGIT_W-1:0] DIGIT_SPLIT  = 6'd10;

   // Divider: quotient bits retired per cycle and division steps per digit
   localparam int BITS_PER_STEP = 8;
   localparam int STEPS         = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_W         = STEPS * BITS_PER_STEP;
   localparam int STEP_W        = (STEPS > 1) ? $clog2(STEPS) : 1;

   // Digit store index width
   localparam int IDX_W = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [RADIX_W-1:0]     radix;
      logic                   upper;
   } req_word_type;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } rsp_word_type;

   // Classified job: base already clamped into range
   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic [RADIX_W-1:0]     base;
      logic                   upper;
   } job_type;

   // Queue status seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Map one digit to its ASCII code
   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] d_ext;
      d_ext = CHAR_W'(d);
      if (d < DIGIT_SPLIT) begin
         digit_char = CHAR_ZERO + d_ext;
      end else begin
         digit_char = d_ext + (upper ? UPPER_OFFSET : LOWER_OFFSET);
      end
   endfunction

endpackage

`default_nettype wire

// ===== sv/utar_front.sv =====
// Front end: accepts request words and clamps the base into range.
// Holds one classified job until the queue takes it. Depends on utar_pkg.
`default_nettype none

module utar_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire utar_pkg::req_word_type    req_word,
   input  wire utar_pkg::queue_status_type q_status,
   output logic                           push,
   output utar_pkg::job_type              job
);
   import utar_pkg::*;

   logic    valid_ff, valid_in;
   job_type job_ff, job_in;
   logic    accept;

   assign accept = start && !valid_ff;
   assign push   = valid_ff && !q_status.full;
   assign busy   = valid_ff;
   assign job    = job_ff;

   // Clamp the base and capture the job
   always_comb begin
      job_in.value = req_word.value;
      job_in.upper = req_word.upper;
      if (req_word.radix inside {[RADIX_MIN:RADIX_MAX]}) begin
         job_in.base = req_word.radix;
      end else if (req_word.radix < RADIX_MIN) begin
         job_in.base = RADIX_MIN;
      end else begin
         job_in.base = RADIX_MAX;
      end
   end

   // Hold until the queue has room
   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         job_ff <= job_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/utar_queue.sv =====
// Two-entry job queue between the front end and the converter.
// Depends on utar_pkg.
`default_nettype none

module utar_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire utar_pkg::job_type    push_job,
   input  wire logic                 pop,
   output utar_pkg::job_type         head_job,
   output utar_pkg::queue_status_type status
);
   import utar_pkg::*;

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign status.full  = (count_ff == 2'd2);
   assign status.empty = (count_ff == 2'd0);
   assign head_job     = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== sv/utar_back.sv =====
// Back end: divides each job by its base, stores digits, then emits them
// most significant first through a registered read and an output register.
// Depends on utar_pkg.
`default_nettype none

module utar_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire utar_pkg::job_type         head_job,
   input  wire utar_pkg::queue_status_type q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   output utar_pkg::rsp_word_type         rsp_word
);
   import utar_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [PAD_W-1:0]    quo_ff, quo_in;
   logic [DIGIT_W-1:0]  rem_ff, rem_in;
   logic [RADIX_W-1:0]  base_ff, base_in;
   logic                upper_ff, upper_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [IDX_W-1:0]    wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]    rd_idx_ff, rd_idx_in;

   logic [DIGIT_W-1:0]  digit_mem [VALUE_WIDTH];
   logic [DIGIT_W-1:0]  mem_q_ff;
   logic                mem_wr;
   logic                mem_rd;

   logic                pend_ff, pend_in;
   logic                pend_last_ff;
   logic                rsp_valid_ff;
   rsp_word_type        rsp_word_ff;

   logic [BITS_PER_STEP-1:0] quo_bits;
   logic [DIGIT_W-1:0]       rem_next;
   logic [PAD_W-1:0]         quo_next;
   logic                     last_step;

   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign last_step = (step_ff == STEP_W'(STEPS - 1));

   // Retire one byte of quotient bits by restoring division
   always_comb begin
      logic [DIGIT_W:0] r;
      r = {1'b0, rem_ff};
      for (int i = 0; i < BITS_PER_STEP; i++) begin
         r = {r[DIGIT_W-1:0], quo_ff[PAD_W-1-i]};
         if (r >= {1'b0, base_ff}) begin
            r = r - {1'b0, base_ff};
            quo_bits[BITS_PER_STEP-1-i] = 1'b1;
         end else begin
            quo_bits[BITS_PER_STEP-1-i] = 1'b0;
         end
      end
      rem_next = r[DIGIT_W-1:0];
      quo_next = {quo_ff[PAD_W-BITS_PER_STEP-1:0], quo_bits};
   end

   // Sequence division and readout
   always_comb begin
      state_in  = state_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      base_in   = base_ff;
      upper_in  = upper_ff;
      step_in   = step_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               quo_in    = PAD_W'(head_job.value);
               rem_in    = '0;
               base_in   = head_job.base;
               upper_in  = head_job.upper;
               step_in   = '0;
               wr_idx_in = '0;
               state_in  = ST_DIV;
            end
         end
         ST_DIV: begin
            quo_in  = quo_next;
            rem_in  = rem_next;
            step_in = step_ff + STEP_W'(1);
            if (last_step) begin
               mem_wr    = 1'b1;
               wr_idx_in = wr_idx_ff + IDX_W'(1);
               rem_in    = '0;
               step_in   = '0;
               if (quo_next == '0) begin
                  rd_idx_in = wr_idx_ff;
                  state_in  = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            mem_rd = 1'b1;
            if (rd_idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               rd_idx_in = rd_idx_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign pend_in = mem_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      base_ff   <= base_in;
      upper_ff  <= upper_in;
      step_ff   <= step_in;
      wr_idx_ff <= wr_idx_in;
      rd_idx_ff <= rd_idx_in;
   end

   // Store digits least significant first
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         digit_mem[wr_idx_ff] <= rem_next;
      end
   end

   // Read digits back most significant first
   always_ff @(posedge clock) begin
      if (mem_rd) begin
         mem_q_ff     <= digit_mem[rd_idx_ff];
         pend_last_ff <= (rd_idx_ff == '0);
      end
   end

   // Register the character for its one-cycle strobe
   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_word_ff.ch   <= digit_char(mem_q_ff, upper_ff);
         rsp_word_ff.last <= pend_last_ff;
      end
   end

endmodule

`default_nettype wire

// ===== sv/unsigned_to_ascii_radix.sv =====
// Unsigned integer to ASCII digits in base 2 to 36, most significant first.
// The divider retires 8 quotient bits per cycle; each digit is formed by division
// steps and stored, and all digits are read out once the quotient reaches zero.
// The longest job is base 2, with 32 digits.
// A two-entry queue lets up to three words wait; results cannot be stalled.
// Synchronous active-high reset clears the states, valid flags and queue pointers; no clearing pass.
`default_nettype none

module unsigned_to_ascii_radix (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire utar_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   output utar_pkg::rsp_word_type      rsp_word
);
   import utar_pkg::*;

   job_type          front_job;
   job_type          head_job;
   logic             push;
   logic             pop;
   queue_status_type q_status;

   utar_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_word (req_word),
      .q_status (q_status),
      .push     (push),
      .job      (front_job)
   );

   utar_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   utar_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

endmodule

`default_nettype wire
